// ----- rtl/mwd_pkg.sv -----
// Shared types and constants for the mecanum waypoint drive step pipeline.
// Used by mwd_sqrt, mwd_div and the top level; depends on nothing.
`default_nettype none

package mwd_pkg;

  // Square root unit: one root bit per stage
  localparam int SQ_BITS  = 26;
  localparam int SQ_WIDTH = 2 * SQ_BITS;

  // Divider unit: one quotient bit per stage, overflow flagged above
  localparam int DV_BITS  = 18;
  localparam int DV_NUM_W = 44;
  localparam int DV_DEN_W = 27;

  // Register stages outside the units: three front, one after the roots,
  // five between the dividers, one output register
  localparam int PIPE_DEPTH = 3 + SQ_BITS + 1 + DV_BITS + 5 + DV_BITS + 1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TARGET_X   = 3'd0,
    REG_TARGET_Y   = 3'd1,
    REG_START_X    = 3'd2,
    REG_START_Y    = 3'd3,
    REG_BASE_SPEED = 3'd4,
    REG_USE_RAMP   = 3'd5
  } cfg_reg_t;

  // Ratio cap (2.0 in Q16) and the 1.0 offset added before squaring
  localparam logic [17:0] RATIO_CAP = 18'd131072;
  localparam logic [17:0] RATIO_ONE = 18'd65536;
  // Reciprocal of ten, exact for operands below 2^22 with a shift of 23
  localparam logic [19:0] RECIP_TEN = 20'hCCCCD;
  localparam int          RECIP_SHIFT = 23;
  // Slow zone radius squared (300 degrees)
  localparam logic [34:0] SLOW_ZONE_SQ = 35'd90000;
  localparam logic [7:0]  TOL_BASE = 8'd100;

  // Per-item data that rides beside the arithmetic units
  typedef struct packed {
    logic        arr;
    logic        near;
    logic        rampup;
    logic        neg0;
    logic        neg1;
    logic [17:0] mag0;
    logic [17:0] mag1;
    logic [SQ_BITS-1:0] len;
  } side_t;

endpackage

`default_nettype wire

// ----- rtl/mecanum_waypoint_drive_step.sv -----
// Top level of the mecanum waypoint drive step: error, arrival, distances,
// ramp speed and wheel mix. Depends on mwd_pkg, mwd_sqrt and mwd_div.
//
//   channel  | signals                              | beat content
//   ---------+--------------------------------------+------------------------------
//   input    | s_tvalid s_tready s_tdata[31:0]      | vert_count, strafe_count
//   output   | m_tvalid m_tready m_tdata[63:0] tuser| four wheel commands, arrived
//   config   | cfg_we cfg_index cfg_data            | six registers, write only
//
// One beat enters per cycle unless stalled; each result passes through ten
// single register stages, the 26-stage root units (side by side) and the
// two 18-stage dividers in series. Reset sets use_ramp and clears the other
// config registers and valid bits. All stages advance together unless a held
// result is not taken; then the whole pipeline and s_tready stall.
`default_nettype none

module mecanum_waypoint_drive_step (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] vert_count, [31:16] strafe_count
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [15:0] front_left_cmd, [31:16] back_left_cmd,
                                      // [47:32] front_right_cmd, [63:48] back_right_cmd
  output logic             m_tuser,   // [0] arrived
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int LAST = mwd_pkg::PIPE_DEPTH - 1;
  localparam int SQW  = mwd_pkg::SQ_WIDTH;
  localparam int SQB  = mwd_pkg::SQ_BITS;

  // Configuration registers
  logic [15:0] target_x, target_y, start_x, start_y;
  logic [6:0]  base_speed;
  logic        use_ramp;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x   <= '0;
      target_y   <= '0;
      start_x    <= '0;
      start_y    <= '0;
      base_speed <= '0;
      use_ramp   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mwd_pkg::REG_TARGET_X:   target_x   <= cfg_data;
        mwd_pkg::REG_TARGET_Y:   target_y   <= cfg_data;
        mwd_pkg::REG_START_X:    start_x    <= cfg_data;
        mwd_pkg::REG_START_Y:    start_y    <= cfg_data;
        mwd_pkg::REG_BASE_SPEED: base_speed <= cfg_data[6:0];
        mwd_pkg::REG_USE_RAMP:   use_ramp   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Global advance and valid bits
  logic                      en;
  logic [mwd_pkg::PIPE_DEPTH-1:0] vld;

  assign en       = ~vld[LAST] | m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[mwd_pkg::PIPE_DEPTH-2:0], s_tvalid};
    end
  end

  // Stage 1: errors and start-to-target vector
  logic signed [17:0] ex1, ey1;
  logic signed [16:0] dx1, dy1;
  logic signed [15:0] vc1, sc1;

  always_ff @(posedge clk) begin
    if (en) begin
      ex1 <= {{2{target_x[15]}}, target_x} - {{2{start_x[15]}}, start_x}
           - {{2{s_tdata[15]}}, s_tdata[15:0]};
      ey1 <= {{2{target_y[15]}}, target_y} - {{2{start_y[15]}}, start_y}
           - {{2{s_tdata[31]}}, s_tdata[31:16]};
      dx1 <= {target_x[15], target_x} - {start_x[15], start_x};
      dy1 <= {target_y[15], target_y} - {start_y[15], start_y};
      vc1 <= s_tdata[15:0];
      sc1 <= s_tdata[31:16];
    end
  end

  // Stage 2: squares and arrival test
  logic [33:0] ex2q, ey2q;
  logic [31:0] dx2q, dy2q;
  logic [30:0] vc2q, sc2q;
  logic signed [17:0] ex2, ey2;
  logic        arr2;
  logic [16:0] abs_ex, abs_ey;
  logic [20:0] tol;
  logic signed [35:0] pex, pey;
  logic signed [33:0] pdx, pdy;
  logic signed [31:0] pvc, psc;

  assign abs_ex = ex1[17] ? 17'(-ex1) : ex1[16:0];
  assign abs_ey = ey1[17] ? 17'(-ey1) : ey1[16:0];
  assign tol    = 21'(mwd_pkg::TOL_BASE) + 21'(base_speed);
  assign pex = ex1 * ex1;
  assign pey = ey1 * ey1;
  assign pdx = dx1 * dx1;
  assign pdy = dy1 * dy1;
  assign pvc = vc1 * vc1;
  assign psc = sc1 * sc1;

  always_ff @(posedge clk) begin
    if (en) begin
      ex2q <= pex[33:0];
      ey2q <= pey[33:0];
      dx2q <= pdx[31:0];
      dy2q <= pdy[31:0];
      vc2q <= pvc[30:0];
      sc2q <= psc[30:0];
      ex2  <= ex1;
      ey2  <= ey1;
      arr2 <= (({4'b0, abs_ex} * 21'd10) < tol) && (({4'b0, abs_ey} * 21'd10) < tol);
    end
  end

  // Stage 3: sums of squares and mixed error magnitudes
  logic [34:0] e2_3;
  logic [31:0] dc2_3;
  logic [32:0] dt2_3;
  logic        arr3, neg0_3, neg1_3;
  logic [17:0] mag0_3, mag1_3;
  logic signed [18:0] n0, n1;

  assign n0 = {ey2[17], ey2} + {ex2[17], ex2};
  assign n1 = {ey2[17], ey2} - {ex2[17], ex2};

  always_ff @(posedge clk) begin
    if (en) begin
      e2_3   <= {1'b0, ex2q} + {1'b0, ey2q};
      dc2_3  <= {1'b0, vc2q} + {1'b0, sc2q};
      dt2_3  <= {1'b0, dx2q} + {1'b0, dy2q};
      arr3   <= arr2;
      neg0_3 <= n0[18];
      neg1_3 <= n1[18];
      mag0_3 <= n0[18] ? 18'(-n0) : n0[17:0];
      mag1_3 <= n1[18] ? 18'(-n1) : n1[17:0];
    end
  end

  // Roots of the three distances, Q8
  logic [SQB-1:0] len_r, dc_r, dt_r;

  mwd_sqrt u_sqrt_len (
    .clk  (clk),
    .en   (en),
    .n    ({{(SQW-51){1'b0}}, e2_3, 16'b0}),
    .root (len_r)
  );

  mwd_sqrt u_sqrt_dc (
    .clk  (clk),
    .en   (en),
    .n    ({{(SQW-48){1'b0}}, dc2_3, 16'b0}),
    .root (dc_r)
  );

  mwd_sqrt u_sqrt_dt (
    .clk  (clk),
    .en   (en),
    .n    ({{(SQW-49){1'b0}}, dt2_3, 16'b0}),
    .root (dt_r)
  );

  // Side data delayed across the root units
  mwd_pkg::side_t side_in;
  mwd_pkg::side_t side_a [SQB];

  always_comb begin
    side_in.arr    = arr3;
    side_in.near   = e2_3 <= mwd_pkg::SLOW_ZONE_SQ;
    side_in.rampup = {dc2_3, 2'b0} < {1'b0, dt2_3};
    side_in.neg0   = neg0_3;
    side_in.neg1   = neg1_3;
    side_in.mag0   = mag0_3;
    side_in.mag1   = mag1_3;
    side_in.len    = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_a[0] <= side_in;
      for (int i = 1; i < SQB; i++) begin
        side_a[i] <= side_a[i-1];
      end
    end
  end

  // Stage 4: ramp denominator, clamped length
  mwd_pkg::side_t side4, side4_next;
  logic [SQB-1:0] den4, dt4, den_c;

  always_comb begin
    if (side_a[SQB-1].rampup) begin
      den_c = (dt_r > dc_r) ? dt_r - dc_r : '0;
    end else begin
      den_c = dc_r;
    end
  end

  always_comb begin
    side4_next     = side_a[SQB-1];
    side4_next.len = (len_r == '0) ? SQB'(1) : len_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4 <= side4_next;
      den4  <= (den_c == '0) ? SQB'(1) : den_c;
      dt4   <= dt_r;
    end
  end

  // Ramp ratio R = dt * 2^16 / den
  logic [mwd_pkg::DV_BITS-1:0] rq;
  logic                        rovf;

  mwd_div u_div_ratio (
    .clk (clk),
    .en  (en),
    .num ({{(mwd_pkg::DV_NUM_W-SQB-16){1'b0}}, dt4, 16'b0}),
    .den ({{(mwd_pkg::DV_DEN_W-SQB){1'b0}}, den4}),
    .quo (rq),
    .ovf (rovf)
  );

  mwd_pkg::side_t side_b [mwd_pkg::DV_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      side_b[0] <= side4;
      for (int i = 1; i < mwd_pkg::DV_BITS; i++) begin
        side_b[i] <= side_b[i-1];
      end
    end
  end

  // Stage 5: cap the ratio, add one, square
  mwd_pkg::side_t side5, side6, side7, side8, side9;
  logic [17:0] r1;
  logic [35:0] rsq5;

  assign r1 = ((rovf || rq > mwd_pkg::RATIO_CAP) ? mwd_pkg::RATIO_CAP : rq)
            + mwd_pkg::RATIO_ONE;

  always_ff @(posedge clk) begin
    if (en) begin
      side5 <= side_b[mwd_pkg::DV_BITS-1];
      rsq5  <= r1 * r1;
    end
  end

  // Stage 6: divide by ten through the reciprocal
  logic [39:0] t6;

  always_ff @(posedge clk) begin
    if (en) begin
      side6 <= side5;
      t6    <= rsq5[35:16] * mwd_pkg::RECIP_TEN;
    end
  end

  // Stage 7: speed in Q16
  logic [22:0] s7;
  logic [15:0] f6;

  assign f6 = t6[mwd_pkg::RECIP_SHIFT+15:mwd_pkg::RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (en) begin
      side7 <= side6;
      if (use_ramp) begin
        s7 <= base_speed * f6;
      end else if (side6.near) begin
        s7 <= {2'b0, base_speed, 14'b0};
      end else begin
        s7 <= {base_speed, 16'b0};
      end
    end
  end

  // Stage 8: scale both mixed errors
  logic [40:0] p0_8, p1_8;

  always_ff @(posedge clk) begin
    if (en) begin
      side8 <= side7;
      p0_8  <= side7.mag0 * s7;
      p1_8  <= side7.mag1 * s7;
    end
  end

  // Stage 9: rounding numerators 2*n*S + L
  logic [mwd_pkg::DV_NUM_W-1:0] a0_9, a1_9;

  always_ff @(posedge clk) begin
    if (en) begin
      side9 <= side8;
      a0_9  <= {2'b0, p0_8, 1'b0} + {{(mwd_pkg::DV_NUM_W-SQB){1'b0}}, side8.len};
      a1_9  <= {2'b0, p1_8, 1'b0} + {{(mwd_pkg::DV_NUM_W-SQB){1'b0}}, side8.len};
    end
  end

  // Wheel quotients over 2L
  logic [mwd_pkg::DV_BITS-1:0] q0, q1;
  logic                        qovf0, qovf1;
  logic [mwd_pkg::DV_DEN_W-1:0] len2;

  assign len2 = {side9.len, 1'b0};

  mwd_div u_div_w0 (
    .clk (clk),
    .en  (en),
    .num (a0_9),
    .den (len2),
    .quo (q0),
    .ovf (qovf0)
  );

  mwd_div u_div_w1 (
    .clk (clk),
    .en  (en),
    .num (a1_9),
    .den (len2),
    .quo (q1),
    .ovf (qovf1)
  );

  mwd_pkg::side_t side_c [mwd_pkg::DV_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      side_c[0] <= side9;
      for (int i = 1; i < mwd_pkg::DV_BITS; i++) begin
        side_c[i] <= side_c[i-1];
      end
    end
  end

  // Stage 10: sign, saturate, zero on arrival
  mwd_pkg::side_t side_o;
  logic [15:0] c0, c1;
  logic [15:0] cmd0, cmd1;
  logic        arr_o;

  assign side_o = side_c[mwd_pkg::DV_BITS-1];

  always_comb begin
    if (side_o.neg0) begin
      cmd0 = (qovf0 || q0 > 18'd32768) ? 16'h8000 : 16'(-q0);
    end else begin
      cmd0 = (qovf0 || q0 > 18'd32767) ? 16'h7FFF : q0[15:0];
    end
    if (side_o.neg1) begin
      cmd1 = (qovf1 || q1 > 18'd32768) ? 16'h8000 : 16'(-q1);
    end else begin
      cmd1 = (qovf1 || q1 > 18'd32767) ? 16'h7FFF : q1[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0    <= side_o.arr ? 16'd0 : cmd0;
      c1    <= side_o.arr ? 16'd0 : cmd1;
      arr_o <= side_o.arr;
    end
  end

  assign m_tdata = {c0, c1, c1, c0};
  assign m_tuser = arr_o;

endmodule

`default_nettype wire

// ----- rtl/mwd_sqrt.sv -----
// Pipelined integer square root, one root bit per stage (floor result).
// Depends on mwd_pkg for its widths.
`default_nettype none

module mwd_sqrt (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [mwd_pkg::SQ_WIDTH-1:0]  n,
  output logic      [mwd_pkg::SQ_BITS-1:0]   root
);

  logic [mwd_pkg::SQ_WIDTH-1:0] rem [mwd_pkg::SQ_BITS];
  logic [mwd_pkg::SQ_BITS-1:0]  rt  [mwd_pkg::SQ_BITS];

  for (genvar i = 0; i < mwd_pkg::SQ_BITS; i++) begin : g_stage
    localparam int B = mwd_pkg::SQ_BITS - 1 - i;
    logic [mwd_pkg::SQ_WIDTH-1:0] rin;
    logic [mwd_pkg::SQ_BITS-1:0]  qin;
    logic [mwd_pkg::SQ_WIDTH-1:0] trial;

    if (i == 0) begin : g_first
      assign rin = n;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem[i-1];
      assign qin = rt[i-1];
    end

    // Trial term for setting this bit: (2*root + 2^B) * 2^B
    assign trial = ({{mwd_pkg::SQ_BITS{1'b0}}, qin} << (B + 1))
                 | ({{(mwd_pkg::SQ_WIDTH-1){1'b0}}, 1'b1} << (2 * B));

    // Keep the bit when the remainder covers the trial term
    always_ff @(posedge clk) begin
      if (en) begin
        if (rin >= trial) begin
          rem[i] <= rin - trial;
          rt[i]  <= qin | ({{(mwd_pkg::SQ_BITS-1){1'b0}}, 1'b1} << B);
        end else begin
          rem[i] <= rin;
          rt[i]  <= qin;
        end
      end
    end
  end

  assign root = rt[mwd_pkg::SQ_BITS-1];

endmodule

`default_nettype wire

// ----- rtl/mwd_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow flag
// for quotients of 2^DV_BITS and above. Depends on mwd_pkg for its widths.
`default_nettype none

module mwd_div (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [mwd_pkg::DV_NUM_W-1:0]  num,
  input  wire logic [mwd_pkg::DV_DEN_W-1:0]  den,
  output logic      [mwd_pkg::DV_BITS-1:0]   quo,
  output logic                               ovf
);

  localparam int CW = mwd_pkg::DV_DEN_W + mwd_pkg::DV_BITS;

  logic [mwd_pkg::DV_NUM_W-1:0] rem [mwd_pkg::DV_BITS];
  logic [mwd_pkg::DV_DEN_W-1:0] dd  [mwd_pkg::DV_BITS];
  logic [mwd_pkg::DV_BITS-1:0]  qq  [mwd_pkg::DV_BITS];
  logic                         of  [mwd_pkg::DV_BITS];

  for (genvar i = 0; i < mwd_pkg::DV_BITS; i++) begin : g_stage
    localparam int B = mwd_pkg::DV_BITS - 1 - i;
    logic [mwd_pkg::DV_NUM_W-1:0] rin;
    logic [mwd_pkg::DV_DEN_W-1:0] din;
    logic [mwd_pkg::DV_BITS-1:0]  qin;
    logic                         oin;
    logic [CW-1:0]                dsh;

    if (i == 0) begin : g_first
      assign rin = num;
      assign din = den;
      assign qin = '0;
      // Quotient does not fit when num >= den * 2^DV_BITS
      assign oin = {{(CW-mwd_pkg::DV_NUM_W){1'b0}}, num}
                   >= {den, {mwd_pkg::DV_BITS{1'b0}}};
    end else begin : g_next
      assign rin = rem[i-1];
      assign din = dd[i-1];
      assign qin = qq[i-1];
      assign oin = of[i-1];
    end

    assign dsh = {{mwd_pkg::DV_BITS{1'b0}}, din} << B;

    // Subtract the shifted divisor when it fits
    always_ff @(posedge clk) begin
      if (en) begin
        dd[i] <= din;
        of[i] <= oin;
        if ({{(CW-mwd_pkg::DV_NUM_W){1'b0}}, rin} >= dsh) begin
          rem[i] <= rin - dsh[mwd_pkg::DV_NUM_W-1:0];
          qq[i]  <= qin | ({{(mwd_pkg::DV_BITS-1){1'b0}}, 1'b1} << B);
        end else begin
          rem[i] <= rin;
          qq[i]  <= qin;
        end
      end
    end
  end

  assign quo = qq[mwd_pkg::DV_BITS-1];
  assign ovf = of[mwd_pkg::DV_BITS-1];

endmodule

`default_nettype wire
